// ----- src/chpt_pkg.sv -----
// ----------------------------------------------------------------------------
// chpt_pkg: shared types and constants for the cuckoo hash prefix table
// Opcodes, status codes, labels, reset prefix length, hash constants and sequencer states.
// ----------------------------------------------------------------------------
package chpt_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    localparam logic [1:0] LBL_EMPTY  = 2'd0;
    localparam logic [1:0] LBL_PREFIX = 2'd1;
    localparam logic [1:0] LBL_MARKER = 2'd2;
    localparam logic [1:0] LBL_BOTH   = 2'd3;

    localparam logic [5:0] PLEN_RESET = 6'd32;

    localparam logic [31:0] HA_M0 = 32'h1835a82b;
    localparam logic [31:0] HA_M1 = 32'h85ebca6b;
    localparam logic [31:0] HA_M2 = 32'hc2b2ae35;
    localparam logic [31:0] HB_C0 = 32'h0193a48b;
    localparam logic [31:0] HB_C1 = 32'h7a11c3e5;
    localparam logic [31:0] HB_C2 = 32'h9f1a0306;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_RD0,
        S_CHK0,
        S_RD1,
        S_CHK1,
        S_KRD,
        S_KCHK,
        S_DONE
    } state_t;

endpackage

// ----- src/cuckoo_hash_prefix_table.sv -----
// ----------------------------------------------------------------------------
// cuckoo_hash_prefix_table: two-way cuckoo hash table of IPv4 prefixes
// Lookup, insert and delete of masked-address keys, one request at a time.
// ----------------------------------------------------------------------------
// After reset a clearing pass empties all 2*SLOTS labels, one slot per cycle,
// before the first word is taken. Every request then runs through a sequencer
// around one single-port table RAM and one shared 32x32 multiplier: the
// multiply/xor hash, then each probe as a RAM read and a compare, and a last
// step that hands the result to the output register. A lookup, delete or
// duplicate insert that hits in table 0 skips the table 1 probe; opcode 3
// and an insert with label 0 skip hashing and probing. An insert that places
// its word adds a read and a write for each placement, and each displaced
// entry is rehashed before its own placement, up to MAX_KICKS placements.
// The result waits in an output register while the next word is accepted;
// a finished request holds until that register is free.
// SLOTS must be a power of two.
module cuckoo_hash_prefix_table #(
    parameter int SLOTS     = 8192,
    parameter int MAX_KICKS = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_address,
    input  logic [1:0]  s_entry_label,
    input  logic [15:0] s_entry_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_found_label,
    output logic [15:0] m_found_data
);
    import chpt_pkg::*;

    localparam int HW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = HW + 1;
    localparam int KW = $clog2(MAX_KICKS + 1);
    localparam int EW = 2 + 32 + 16;
    localparam logic [AW-1:0] LAST_SLOT = AW'(2 * SLOTS - 1);

    state_t state_reg, state_next;
    logic [5:0]    plen_reg;
    logic [1:0]    op_reg, op_next;
    logic [31:0]   key_reg, key_next;
    logic [1:0]    lab_reg, lab_next;
    logic [15:0]   dat_reg, dat_next;
    logic [HW-1:0] ha_reg, ha_next, hb_reg, hb_next;
    logic [31:0]   acc_reg, acc_next;
    logic [1:0]    hstep_reg, hstep_next;
    logic [KW-1:0] kick_reg, kick_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          vld_reg, vld_next;
    logic [1:0]    st_reg, st_next;
    logic [1:0]    fl_reg, fl_next;
    logic [15:0]   fd_reg, fd_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic [1:0]    res_fl_reg, res_fl_next;
    logic [15:0]   res_fd_reg, res_fd_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [1:0]    rd_lab;
    logic [31:0]   rd_key;
    logic [15:0]   rd_dat;
    logic [31:0]   mul_a, mul_b, mul_p;
    logic [31:0]   hb_sum;
    logic [31:0]   mkey;
    logic [5:0]    plen_c;
    logic          hit;

    assign {rd_lab, rd_key, rd_dat} = ram_rdata;
    assign hit = (rd_lab != LBL_EMPTY) && (rd_key == key_reg);

    // one table: label, key, payload per slot; table 1 sits above table 0
    chpt_ram #(.WIDTH(EW), .DEPTH(2 * SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // key masking
    always_comb begin
        plen_c = (plen_reg > 6'd32) ? 6'd32 : plen_reg;
        if (plen_c == 6'd0) begin
            mkey = 32'd0;
        end else begin
            mkey = s_address & (32'hffffffff << (6'd32 - plen_c));
        end
    end

    // add/subtract hash of the current key, constants folded
    always_comb begin
        hb_sum = (key_reg << 1) + (key_reg >> 24) + (key_reg >> 16) + (key_reg >> 8)
               - (HB_C0 + HB_C1 + HB_C2);
    end

    // shared multiplier
    assign mul_p = mul_a * mul_b;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= PLEN_RESET;
        end else if (cfg_valid) begin
            plen_reg <= cfg_data;
        end
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            vld_reg   <= vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        lab_reg    <= lab_next;
        dat_reg    <= dat_next;
        ha_reg     <= ha_next;
        hb_reg     <= hb_next;
        acc_reg    <= acc_next;
        hstep_reg  <= hstep_next;
        kick_reg   <= kick_next;
        st_reg     <= st_next;
        fl_reg     <= fl_next;
        fd_reg     <= fd_next;
        res_st_reg <= res_st_next;
        res_fl_reg <= res_fl_next;
        res_fd_reg <= res_fd_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = vld_reg;
    assign m_status      = res_st_reg;
    assign m_found_label = res_fl_reg;
    assign m_found_data  = res_fd_reg;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        lab_next    = lab_reg;
        dat_next    = dat_reg;
        ha_next     = ha_reg;
        hb_next     = hb_reg;
        acc_next    = acc_reg;
        hstep_next  = hstep_reg;
        kick_next   = kick_reg;
        clr_next    = clr_reg;
        vld_next    = vld_reg;
        st_next     = st_reg;
        fl_next     = fl_reg;
        fd_next     = fd_reg;
        res_st_next = res_st_reg;
        res_fl_next = res_fl_reg;
        res_fd_next = res_fd_reg;
        ram_we      = 1'b0;
        ram_addr    = {1'b0, ha_reg};
        ram_wdata   = {lab_reg, key_reg, dat_reg};
        mul_a       = acc_reg;
        mul_b       = HA_M0;

        if (vld_reg && m_ready) begin
            vld_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next    = s_opcode;
                    key_next   = mkey;
                    lab_next   = s_entry_label;
                    dat_next   = s_entry_data;
                    st_next    = ST_OK;
                    fl_next    = LBL_EMPTY;
                    fd_next    = '0;
                    kick_next  = '0;
                    acc_next   = '0;
                    hstep_next = 2'd0;
                    if ((s_opcode == OP_INSERT && s_entry_label != LBL_EMPTY) ||
                        s_opcode == OP_LOOKUP || s_opcode == OP_DELETE) begin
                        state_next = S_HASH;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_HASH: begin
                // multiply/xor hash, one multiply a cycle
                case (hstep_reg)
                    2'd0: begin
                        mul_a    = 32'd0;
                        mul_b    = HA_M0;
                        acc_next = mul_p ^ (key_reg >> 8);
                    end
                    2'd1: begin
                        mul_b    = HA_M1;
                        acc_next = mul_p ^ (key_reg >> 16);
                    end
                    2'd2: begin
                        mul_b    = HA_M2;
                        acc_next = mul_p ^ (key_reg >> 24);
                    end
                    default: begin
                        ha_next = acc_reg[HW-1:0];
                        hb_next = hb_sum[HW-1:0];
                    end
                endcase
                hstep_next = hstep_reg + 2'd1;
                if (hstep_reg == 2'd3) begin
                    state_next = (kick_reg != '0) ? S_KRD : S_RD0;
                end
            end
            S_RD0: begin
                ram_addr   = {1'b0, ha_reg};
                state_next = S_CHK0;
            end
            S_CHK0: begin
                ram_addr = {1'b0, ha_reg};
                if (hit) begin
                    state_next = S_DONE;
                    if (op_reg == OP_LOOKUP) begin
                        fl_next = rd_lab;
                        fd_next = rd_dat;
                    end else if (op_reg == OP_DELETE) begin
                        ram_we    = 1'b1;
                        ram_wdata = '0;
                    end else begin
                        st_next = ST_DUP;
                        if (rd_lab == LBL_PREFIX && lab_reg == LBL_MARKER) begin
                            ram_we    = 1'b1;
                            ram_wdata = {LBL_BOTH, rd_key, rd_dat};
                        end
                    end
                end else begin
                    state_next = S_RD1;
                end
            end
            S_RD1: begin
                ram_addr   = {1'b1, hb_reg};
                state_next = S_CHK1;
            end
            S_CHK1: begin
                ram_addr   = {1'b1, hb_reg};
                state_next = S_DONE;
                if (hit) begin
                    if (op_reg == OP_LOOKUP) begin
                        fl_next = rd_lab;
                        fd_next = rd_dat;
                    end else if (op_reg == OP_DELETE) begin
                        ram_we    = 1'b1;
                        ram_wdata = '0;
                    end else begin
                        st_next = ST_DUP;
                        if (rd_lab == LBL_PREFIX && lab_reg == LBL_MARKER) begin
                            ram_we    = 1'b1;
                            ram_wdata = {LBL_BOTH, rd_key, rd_dat};
                        end
                    end
                end else if (op_reg == OP_INSERT) begin
                    state_next = S_KRD;
                end else begin
                    st_next = ST_MISS;
                end
            end
            S_KRD: begin
                // placement read: even placements go to table 0, odd to table 1
                ram_addr   = kick_reg[0] ? {1'b1, hb_reg} : {1'b0, ha_reg};
                state_next = S_KCHK;
            end
            S_KCHK: begin
                ram_addr  = kick_reg[0] ? {1'b1, hb_reg} : {1'b0, ha_reg};
                ram_we    = 1'b1;
                ram_wdata = {lab_reg, key_reg, dat_reg};
                kick_next = kick_reg + KW'(1);
                if (rd_lab == LBL_EMPTY) begin
                    state_next = S_DONE;
                end else if (kick_reg == KW'(MAX_KICKS - 1)) begin
                    st_next    = ST_LIMIT;
                    state_next = S_DONE;
                end else begin
                    // carry the displaced entry and rehash it
                    key_next   = rd_key;
                    lab_next   = rd_lab;
                    dat_next   = rd_dat;
                    acc_next   = '0;
                    hstep_next = 2'd0;
                    state_next = S_HASH;
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!vld_reg || m_ready) begin
                    vld_next    = 1'b1;
                    res_st_next = st_reg;
                    res_fl_next = fl_reg;
                    res_fd_next = fd_reg;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a result only appears after the sequencer finishes a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result without finished request");

    // a waiting result holds its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) &&
                                   $stable(m_found_label) && $stable(m_found_data)))
        else $error("pending result changed");

    // placement count stays within the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_KCHK) |-> (kick_reg < KW'(MAX_KICKS)))
        else $error("placement count overrun");
`endif

endmodule

// ----- src/chpt_ram.sv -----
// ----------------------------------------------------------------------------
// chpt_ram: generic single-port RAM
// One address per cycle, written or read; read data is registered and shows the old word on a write.
// ----------------------------------------------------------------------------
module chpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write, and registered read of the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

// ----- tb/cuckoo_hash_prefix_table_tb.sv -----
// ----------------------------------------------------------------------------
// cuckoo_hash_prefix_table_tb: self-checking bench for the prefix hash table
// Directed and random lookup/insert/delete/no-op words over several prefix lengths,
// checked against a cycle-free table predictor, with random stalls on both sides.
// ----------------------------------------------------------------------------
module cuckoo_hash_prefix_table_tb;
    import chpt_pkg::*;

    localparam int NSLOT     = 8192;
    localparam int KICKS     = 50;
    localparam int WDOG_MAX  = 60000;
    localparam int SETTLE    = 40;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct {
        logic [1:0]  status;
        logic [1:0]  label;
        logic [15:0] data;
    } lookup_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [31:0] s_address = '0;
    logic [1:0]  s_entry_label = '0;
    logic [15:0] s_entry_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [1:0]  m_found_label;
    logic [15:0] m_found_data;

    // table shadow
    logic [1:0]  tbl_label [2*NSLOT];
    logic [31:0] tbl_key   [2*NSLOT];
    logic [15:0] tbl_data  [2*NSLOT];
    logic [5:0]  cur_plen;

    lookup_result_t pending_results[$];
    logic [31:0]    addr_pool[$];
    int             err_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             idle_cycles = 0;

    cuckoo_hash_prefix_table #(.SLOTS(NSLOT), .MAX_KICKS(KICKS)) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_address    (s_address),
        .s_entry_label(s_entry_label),
        .s_entry_data (s_entry_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found_label(m_found_label),
        .m_found_data (m_found_data)
    );

    always #4 aclk = ~aclk;

    // hash helpers
    function automatic logic [12:0] mix_hash(logic [31:0] k);
        logic [31:0] h;
        h = k >> 8;
        h = h * HA_M1;
        h = h ^ (k >> 16);
        h = h * HA_M2;
        h = h ^ (k >> 24);
        return h[12:0];
    endfunction

    function automatic logic [12:0] sum_hash(logic [31:0] k);
        logic [31:0] h;
        h = k + (k >> 24) - HB_C0 + (k >> 16) - HB_C1 + (k >> 8) - HB_C2 + k;
        return h[12:0];
    endfunction

    function automatic int slot_index(int t, logic [31:0] k);
        return t ? NSLOT + int'(sum_hash(k)) : int'(mix_hash(k));
    endfunction

    function automatic logic [31:0] masked_key(logic [31:0] a);
        int p;
        p = (cur_plen > 32) ? 32 : int'(cur_plen);
        if (p == 0) return 32'd0;
        return a & (32'hffff_ffff << (32 - p));
    endfunction

    function automatic int find_entry(logic [31:0] k);
        int s;
        for (int t = 0; t < 2; t++) begin
            s = slot_index(t, k);
            if (tbl_label[s] != LBL_EMPTY && tbl_key[s] == k) return s;
        end
        return -1;
    endfunction

    // table update and expected word for one request
    function automatic lookup_result_t apply_request(logic [1:0] op, logic [31:0] a,
                                                     logic [1:0] lab, logic [15:0] dat);
        lookup_result_t r;
        logic [31:0] k, ok;
        logic [1:0]  ol;
        logic [15:0] od;
        int s, idx;
        r = '{ST_OK, LBL_EMPTY, 16'd0};
        k = masked_key(a);
        if (op == OP_LOOKUP) begin
            s = find_entry(k);
            if (s < 0) r.status = ST_MISS;
            else begin
                r.label = tbl_label[s];
                r.data  = tbl_data[s];
            end
        end else if (op == OP_INSERT && lab != LBL_EMPTY) begin
            s = find_entry(k);
            if (s >= 0) begin
                if (tbl_label[s] == LBL_PREFIX && lab == LBL_MARKER) tbl_label[s] = LBL_BOTH;
                r.status = ST_DUP;
            end else begin
                r.status = ST_LIMIT;
                for (int i = 0; i < KICKS; i++) begin
                    idx = slot_index(i & 1, k);
                    ok = tbl_key[idx];
                    ol = tbl_label[idx];
                    od = tbl_data[idx];
                    tbl_key[idx] = k;
                    tbl_label[idx] = lab;
                    tbl_data[idx] = dat;
                    if (ol == LBL_EMPTY) begin
                        r.status = ST_OK;
                        break;
                    end
                    k = ok;
                    lab = ol;
                    dat = od;
                end
            end
        end else if (op == OP_DELETE) begin
            s = find_entry(k);
            if (s < 0) r.status = ST_MISS;
            else tbl_label[s] = LBL_EMPTY;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word status", m_status, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) report_mismatch("status", m_status, want.status);
                if (m_found_label !== want.label)
                    report_mismatch("found_label", m_found_label, want.label);
                if (m_found_data !== want.data)
                    report_mismatch("found_data", m_found_data, want.data);
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WDOG_MAX) begin
            $display("cuckoo_hash_prefix_table_tb failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_word(logic [1:0] op, logic [31:0] a, logic [1:0] lab,
                             logic [15:0] dat);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid = 1'b1;
        s_opcode = op;
        s_address = a;
        s_entry_label = lab;
        s_entry_data = dat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_request(op, a, lab, dat));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_prefix_length(logic [5:0] v);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data = v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cur_plen = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // exact-match operations at full prefix, including the label upgrade
    task automatic test_full_prefix();
        send_word(OP_LOOKUP, 32'h0a00_0001, LBL_EMPTY, 16'h0);
        send_word(OP_INSERT, 32'hffff_ffff, LBL_PREFIX, 16'hffff);
        send_word(OP_INSERT, 32'hffff_ffff, LBL_MARKER, 16'h1234);
        send_word(OP_LOOKUP, 32'hffff_ffff, LBL_EMPTY, 16'h0);
        send_word(OP_INSERT, 32'h0000_0000, LBL_MARKER, 16'h0000);
        send_word(OP_INSERT, 32'h0000_0000, LBL_PREFIX, 16'h5555);
        send_word(OP_INSERT, 32'hc0a8_0101, LBL_BOTH, 16'haaaa);
        send_word(OP_INSERT, 32'h0102_0304, LBL_EMPTY, 16'h7777);
        send_word(OP_LOOKUP, 32'h0102_0304, LBL_EMPTY, 16'h0);
        send_word(OP_NOP, 32'hc0a8_0101, LBL_BOTH, 16'hffff);
        send_word(OP_LOOKUP, 32'hc0a8_0101, LBL_EMPTY, 16'h0);
        send_word(OP_DELETE, 32'hffff_ffff, LBL_EMPTY, 16'h0);
        send_word(OP_DELETE, 32'hffff_ffff, LBL_EMPTY, 16'h0);
        send_word(OP_LOOKUP, 32'h0000_0000, LBL_EMPTY, 16'h0);
    endtask

    // zero and oversized prefix lengths
    task automatic test_prefix_extremes();
        write_prefix_length(6'd0);
        send_word(OP_INSERT, 32'h8765_4321, LBL_PREFIX, 16'hbeef);
        send_word(OP_LOOKUP, 32'h1234_5678, LBL_EMPTY, 16'h0);
        send_word(OP_INSERT, 32'hffff_ffff, LBL_MARKER, 16'h0);
        send_word(OP_DELETE, 32'h0000_0001, LBL_EMPTY, 16'h0);
        write_prefix_length(6'd63);
        send_word(OP_LOOKUP, 32'hc0a8_0101, LBL_EMPTY, 16'h0);
        send_word(OP_INSERT, 32'hc0a8_0102, LBL_PREFIX, 16'h0102);
        send_word(OP_LOOKUP, 32'hc0a8_0102, LBL_EMPTY, 16'h0);
        write_prefix_length(6'd33);
        send_word(OP_LOOKUP, 32'hc0a8_0102, LBL_EMPTY, 16'h0);
    endtask

    // random words, mostly on a small address pool to hit and displace entries
    task automatic test_random(int count, logic [5:0] plen, int idle_pct, int stall_pct);
        logic [1:0]  op;
        logic [31:0] a;
        logic [1:0]  lab;
        int          pick;
        write_prefix_length(plen);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        addr_pool.delete();
        repeat (64) addr_pool.push_back($urandom);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            op = (pick < 45) ? OP_INSERT : (pick < 75) ? OP_LOOKUP :
                 (pick < 95) ? OP_DELETE : OP_NOP;
            a = ($urandom_range(9) < 8) ? addr_pool[$urandom_range(63)] : $urandom;
            lab = ($urandom_range(99) < 3) ? LBL_EMPTY : 2'($urandom_range(3, 1));
            // stretches with no gaps on either side
            if (n % 100 == 50) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end else if (n % 100 == 80) begin
                send_idle_pct = idle_pct;
                recv_stall_pct = stall_pct;
            end
            send_word(op, a, lab, 16'($urandom));
        end
        send_idle_pct = 0;
    endtask

    // sender holds off until the table has answered everything
    task automatic test_drain_pause();
        send_word(OP_INSERT, 32'h0a0b_0c0d, LBL_PREFIX, 16'h0c0d);
        wait_drained();
        send_word(OP_LOOKUP, 32'h0a0b_0c0d, LBL_EMPTY, 16'h0);
    endtask

    initial begin
        for (int i = 0; i < 2*NSLOT; i++) begin
            tbl_label[i] = LBL_EMPTY;
            tbl_key[i] = '0;
            tbl_data[i] = '0;
        end
        cur_plen = PLEN_RESET;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_full_prefix();
        write_prefix_length(6'd32);
        test_drain_pause();
        test_prefix_extremes();
        test_random(430, 6'd24, 12, 53);
        test_random(430, 6'd8, 53, 12);
        test_random(230, 6'd32, 0, 0);
        test_random(200, 6'($urandom_range(32)), 0, 0);

        wait_drained();
        if (err_count == 0)
            $display("cuckoo_hash_prefix_table_tb passed");
        else
            $display("cuckoo_hash_prefix_table_tb failed");
        $finish;
    end

endmodule
